// File: design/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants, term and control types for the sparse polynomial adder.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MaxTerms  = 16;  // terms per store, 1..32
  localparam int CoefWidth = 16;  // coefficient width, 4..32
  localparam int ExpWidth  = 8;
  localparam int SumWidth  = CoefWidth + 1;

  // command codes
  localparam logic [1:0] CmdLoadFirst  = 2'd0;
  localparam logic [1:0] CmdLoadSecond = 2'd1;
  localparam logic [1:0] CmdAdd        = 2'd2;

  // status codes
  localparam logic [1:0] StatStored = 2'd0;
  localparam logic [1:0] StatFull   = 2'd1;
  localparam logic [1:0] StatSum    = 2'd2;
  localparam logic [1:0] StatZero   = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic [ExpWidth-1:0]  expo;
    logic [CoefWidth-1:0] coef;
  } term_t;

  // per-chain control: insert broadcasts a term, pop shifts toward the head
  typedef struct packed {
    logic                 insert;
    logic                 pop;
    logic [ExpWidth-1:0]  expo;
    logic [CoefWidth-1:0] coef;
  } ctrl_t;

endpackage

// File: design/spa_cell.sv
// ----------------------------------------------------------------------------
// spa_cell
// One slot of a sorted term chain. Keeps, takes the new term, or takes a
// neighbor's term, depending on the broadcast command and the compares.
// ----------------------------------------------------------------------------
module spa_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spa_pkg::ctrl_t ctrl_i,
  input  spa_pkg::term_t prev_i,     // toward head
  input  logic          prev_ge_i,   // previous slot stays put on insert
  input  spa_pkg::term_t next_i,     // toward tail
  output spa_pkg::term_t term_o,
  output logic          ge_o
);

  logic                          valid_q, valid_d;
  logic [spa_pkg::ExpWidth-1:0]  expo_q, expo_d;
  logic [spa_pkg::CoefWidth-1:0] coef_q, coef_d;

  // stored term sorts before (or ties with) the new one
  assign ge_o = valid_q && (expo_q >= ctrl_i.expo);

  always_comb begin
    valid_d = valid_q;
    expo_d  = expo_q;
    coef_d  = coef_q;
    if (ctrl_i.insert) begin
      if (!ge_o) begin
        if (prev_ge_i) begin
          valid_d = 1'b1;
          expo_d  = ctrl_i.expo;
          coef_d  = ctrl_i.coef;
        end else begin
          valid_d = prev_i.valid;
          expo_d  = prev_i.expo;
          coef_d  = prev_i.coef;
        end
      end
    end else if (ctrl_i.pop) begin
      valid_d = next_i.valid;
      expo_d  = next_i.expo;
      coef_d  = next_i.coef;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    expo_q <= expo_d;
    coef_q <= coef_d;
  end

  assign term_o = '{valid: valid_q, expo: expo_q, coef: coef_q};

endmodule

// File: design/spa_chain.sv
// ----------------------------------------------------------------------------
// spa_chain
// Row of cells holding one store in descending exponent order, head at slot 0.
// ----------------------------------------------------------------------------
module spa_chain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spa_pkg::ctrl_t ctrl_i,
  output spa_pkg::term_t head_o,
  output logic           full_o
);

  spa_pkg::term_t terms [spa_pkg::MaxTerms];
  logic           ge    [spa_pkg::MaxTerms];

  for (genvar i = 0; i < spa_pkg::MaxTerms; i++) begin : g_cell
    spa_pkg::term_t prev, next;
    logic           prev_ge;

    if (i == 0) begin : g_head
      assign prev    = '0;
      assign prev_ge = 1'b1;
    end else begin : g_body
      assign prev    = terms[i-1];
      assign prev_ge = ge[i-1];
    end

    if (i == spa_pkg::MaxTerms - 1) begin : g_tail
      assign next = '0;
    end else begin : g_inner
      assign next = terms[i+1];
    end

    spa_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .prev_i    (prev),
      .prev_ge_i (prev_ge),
      .next_i    (next),
      .term_o    (terms[i]),
      .ge_o      (ge[i])
    );
  end

  assign head_o = terms[0];
  assign full_o = terms[spa_pkg::MaxTerms-1].valid;

endmodule

// File: design/sparse_polynomial_adder.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_adder
// Two sorted term chains; loads insert in place, add merges the chain heads.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_ready_o   command_i, exponent_i, coefficient_i
//   out      out  out_valid_o/out_ready_i status_o, result_exponent_o,
//                                         result_coefficient_o, last_o
//
// Load: the sorted insert happens across the cell row in the accepting cycle.
// Add: one merge step per cycle while the output does not stall it (at most
//   2*MaxTerms steps), then a check that sees both chains empty, then a flush
//   step; the last nonzero term is held back one step so it can carry last.
// Reset empties both chains. A stalled output stalls the merge step that
// would overwrite the held term; no new word is taken until the add is done.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           command_i,
  input  logic [spa_pkg::ExpWidth-1:0]         exponent_i,
  input  logic signed [spa_pkg::CoefWidth-1:0] coefficient_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic [spa_pkg::ExpWidth-1:0]         result_exponent_o,
  output logic signed [spa_pkg::SumWidth-1:0]  result_coefficient_o,
  output logic                                 last_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StMerge = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0] state_q, state_d;

  spa_pkg::ctrl_t ctrl_a, ctrl_b;
  spa_pkg::term_t head_a, head_b;
  logic           full_a, full_b;

  spa_chain u_chain_a (.clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl_a),
                       .head_o(head_a), .full_o(full_a));
  spa_chain u_chain_b (.clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl_b),
                       .head_o(head_b), .full_o(full_b));

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [1:0]                     status_q, status_d;
  logic [spa_pkg::ExpWidth-1:0]   rexp_q, rexp_d;
  logic [spa_pkg::SumWidth-1:0]   rcoef_q, rcoef_d;
  logic                           last_q, last_d;

  // held sum term
  logic                           hold_valid_q, hold_valid_d;
  logic [spa_pkg::ExpWidth-1:0]   hold_exp_q, hold_exp_d;
  logic [spa_pkg::SumWidth-1:0]   hold_coef_q, hold_coef_d;

  logic out_free, accept;
  logic take_a, take_b, take_both, chains_empty, term_keep, stall;
  logic [spa_pkg::SumWidth-1:0] ext_a, ext_b, sum_ab, term_coef;
  logic [spa_pkg::ExpWidth-1:0] term_exp;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // merge step on the two heads
  assign ext_a     = {head_a.coef[spa_pkg::CoefWidth-1], head_a.coef};
  assign ext_b     = {head_b.coef[spa_pkg::CoefWidth-1], head_b.coef};
  assign sum_ab    = ext_a + ext_b;
  assign take_a    = head_a.valid && (!head_b.valid || head_a.expo > head_b.expo);
  assign take_b    = head_b.valid && (!head_a.valid || head_b.expo > head_a.expo);
  assign take_both = head_a.valid && head_b.valid && (head_a.expo == head_b.expo);
  assign chains_empty = !head_a.valid && !head_b.valid;
  assign term_exp  = take_b ? head_b.expo : head_a.expo;
  assign term_coef = take_a ? ext_a : (take_b ? ext_b : sum_ab);
  assign term_keep = !take_both || (sum_ab != '0);
  assign stall     = term_keep && hold_valid_q && !out_free;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    rexp_d       = rexp_q;
    rcoef_d      = rcoef_q;
    last_d       = last_q;
    hold_valid_d = hold_valid_q;
    hold_exp_d   = hold_exp_q;
    hold_coef_d  = hold_coef_q;
    ctrl_a       = '{insert: 1'b0, pop: 1'b0, expo: exponent_i, coef: coefficient_i};
    ctrl_b       = '{insert: 1'b0, pop: 1'b0, expo: exponent_i, coef: coefficient_i};

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (command_i)
            spa_pkg::CmdLoadFirst, spa_pkg::CmdLoadSecond: begin
              if (command_i == spa_pkg::CmdLoadFirst) begin
                ctrl_a.insert = !full_a;
                status_d      = full_a ? spa_pkg::StatFull : spa_pkg::StatStored;
              end else begin
                ctrl_b.insert = !full_b;
                status_d      = full_b ? spa_pkg::StatFull : spa_pkg::StatStored;
              end
              out_valid_d = 1'b1;
              rexp_d      = '0;
              rcoef_d     = '0;
              last_d      = 1'b1;
            end
            spa_pkg::CmdAdd: begin
              hold_valid_d = 1'b0;
              state_d      = StMerge;
            end
            default: ;  // unused command: dropped
          endcase
        end
      end
      StMerge: begin
        if (chains_empty) begin
          state_d = StFlush;
        end else if (!stall) begin
          ctrl_a.pop = take_a || take_both;
          ctrl_b.pop = take_b || take_both;
          if (term_keep) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              status_d    = spa_pkg::StatSum;
              rexp_d      = hold_exp_q;
              rcoef_d     = hold_coef_q;
              last_d      = 1'b0;
            end
            hold_valid_d = 1'b1;
            hold_exp_d   = term_exp;
            hold_coef_d  = term_coef;
          end
        end
      end
      StFlush: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          last_d       = 1'b1;
          status_d     = hold_valid_q ? spa_pkg::StatSum : spa_pkg::StatZero;
          rexp_d       = hold_valid_q ? hold_exp_q : '0;
          rcoef_d      = hold_valid_q ? hold_coef_q : '0;
          hold_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    rexp_q      <= rexp_d;
    rcoef_q     <= rcoef_d;
    last_q      <= last_d;
    hold_exp_q  <= hold_exp_d;
    hold_coef_q <= hold_coef_d;
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign result_exponent_o    = rexp_q;
  assign result_coefficient_o = rcoef_q;
  assign last_o               = last_q;

endmodule

// File: bench/spa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spa_checker
// Watches both channels of the sparse polynomial adder, keeps its own copy of
// the two sorted term stores, predicts every result word and checks them in
// order.
// ----------------------------------------------------------------------------
module spa_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [1:0]                           command_i,
  input  logic [spa_pkg::ExpWidth-1:0]         exponent_i,
  input  logic signed [spa_pkg::CoefWidth-1:0] coefficient_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [1:0]                           status_i,
  input  logic [spa_pkg::ExpWidth-1:0]         result_exponent_i,
  input  logic signed [spa_pkg::SumWidth-1:0]  result_coefficient_i,
  input  logic                                 last_i,
  output int                                   pending_o,
  output int                                   fail_count_o
);

  typedef struct packed {
    logic [spa_pkg::ExpWidth-1:0]         expo;
    logic signed [spa_pkg::CoefWidth-1:0] coef;
  } mono_t;

  typedef struct packed {
    logic [1:0]                          status;
    logic [spa_pkg::ExpWidth-1:0]        expo;
    logic signed [spa_pkg::SumWidth-1:0] coef;
    logic                                last;
  } sum_word_t;

  mono_t     first_poly[$];
  mono_t     second_poly[$];
  sum_word_t expected_words[$];
  int        mismatches;

  task automatic load_term(input logic to_second, input mono_t t);
    sum_word_t w;
    int        pos;
    w = '{spa_pkg::StatStored, '0, '0, 1'b1};
    pos = 0;
    if (to_second) begin
      if (second_poly.size() >= spa_pkg::MaxTerms) begin
        w.status = spa_pkg::StatFull;
      end else begin
        // equal exponents go after the ones already stored
        while (pos < second_poly.size() && second_poly[pos].expo >= t.expo) pos++;
        second_poly.insert(pos, t);
      end
    end else begin
      if (first_poly.size() >= spa_pkg::MaxTerms) begin
        w.status = spa_pkg::StatFull;
      end else begin
        while (pos < first_poly.size() && first_poly[pos].expo >= t.expo) pos++;
        first_poly.insert(pos, t);
      end
    end
    expected_words.push_back(w);
  endtask

  task automatic add_polys();
    int                                  a;
    int                                  b;
    logic                                keep;
    logic                                have_held;
    logic signed [spa_pkg::SumWidth-1:0] sum;
    logic [spa_pkg::ExpWidth-1:0]        e;
    sum_word_t                           held;
    a = 0;
    b = 0;
    have_held = 1'b0;
    held = '0;
    while (a < first_poly.size() || b < second_poly.size()) begin
      keep = 1'b1;
      if (b >= second_poly.size() ||
          (a < first_poly.size() && first_poly[a].expo > second_poly[b].expo)) begin
        e = first_poly[a].expo;
        sum = $signed(first_poly[a].coef);
        a++;
      end else if (a >= first_poly.size() ||
                   first_poly[a].expo < second_poly[b].expo) begin
        e = second_poly[b].expo;
        sum = $signed(second_poly[b].coef);
        b++;
      end else begin
        e = first_poly[a].expo;
        sum = $signed(first_poly[a].coef) + $signed(second_poly[b].coef);
        a++;
        b++;
        keep = (sum != 0);
      end
      if (keep) begin
        // hold one word back so the final one can carry last
        if (have_held) expected_words.push_back(held);
        held = '{spa_pkg::StatSum, e, sum, 1'b0};
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_words.push_back(held);
    end else begin
      expected_words.push_back('{spa_pkg::StatZero, '0, '0, 1'b1});
    end
    first_poly.delete();
    second_poly.delete();
  endtask

  task automatic check_word();
    sum_word_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result word: status %0d expo %0d coef %0d last %0b",
                 $realtime, status_i, result_exponent_i, result_coefficient_i, last_i);
    end else begin
      want = expected_words.pop_front();
      if (status_i !== want.status || result_exponent_i !== want.expo ||
          result_coefficient_i !== want.coef || last_i !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch st/exp/coef/last: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                   $realtime, want.status, want.expo, $signed(want.coef), want.last,
                   status_i, result_exponent_i, result_coefficient_i, last_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_poly.delete();
      second_poly.delete();
      expected_words.delete();
      mismatches = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // predict first so a word can never race its own expectation
      if (in_valid_i && in_ready_i) begin
        case (command_i)
          spa_pkg::CmdLoadFirst:  load_term(1'b0, '{exponent_i, coefficient_i});
          spa_pkg::CmdLoadSecond: load_term(1'b1, '{exponent_i, coefficient_i});
          spa_pkg::CmdAdd:        add_polys();
          default:                ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_word();
      pending_o <= expected_words.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: bench/tb_sparse_polynomial_adder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_adder
// Drives load and add words into the sparse polynomial adder with random
// gaps and output stalls; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_adder;

  localparam logic [1:0] CmdUnused  = 2'd3;  // no name in the block; ignored
  localparam int         QuietLimit = 2000;
  localparam int         HoldCycles = 300;
  localparam int         TailCycles = 2 * spa_pkg::MaxTerms + 8;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [1:0]                           command = spa_pkg::CmdLoadFirst;
  logic [spa_pkg::ExpWidth-1:0]         exponent = '0;
  logic signed [spa_pkg::CoefWidth-1:0] coefficient = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [1:0]                           status;
  logic [spa_pkg::ExpWidth-1:0]         result_exponent;
  logic signed [spa_pkg::SumWidth-1:0]  result_coefficient;
  logic                                 last;

  int   pending;
  int   fail_count;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   words_sent = 0;
  int   quiet_cycles = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always #2 clk = ~clk;

  sparse_polynomial_adder dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .command_i            (command),
    .exponent_i           (exponent),
    .coefficient_i        (coefficient),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .status_o             (status),
    .result_exponent_o    (result_exponent),
    .result_coefficient_o (result_coefficient),
    .last_o               (last)
  );

  spa_checker u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .command_i            (command),
    .exponent_i           (exponent),
    .coefficient_i        (coefficient),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .status_i             (status),
    .result_exponent_i    (result_exponent),
    .result_coefficient_i (result_coefficient),
    .last_i               (last),
    .pending_o            (pending),
    .fail_count_o         (fail_count)
  );

  // receiver: random backpressure, plus a long hold-off when hold_go flips
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [spa_pkg::ExpWidth-1:0] e,
                           input logic signed [spa_pkg::CoefWidth-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    exponent <= e;
    coefficient <= c;
    do @(posedge clk); while (!in_ready);
    if (cmd != CmdUnused) words_sent++;
  endtask

  // pending is registered, so look from the cycle after the last acceptance
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int pick_size();
    if ($urandom_range(9) == 0)
      return $urandom_range(spa_pkg::MaxTerms + 2, spa_pkg::MaxTerms - 2);
    return $urandom_range(5);
  endfunction

  function automatic logic signed [spa_pkg::CoefWidth-1:0] pick_coef();
    case ($urandom_range(9))
      0:       return {1'b0, {(spa_pkg::CoefWidth-1){1'b1}}};
      1:       return {1'b1, {(spa_pkg::CoefWidth-1){1'b0}}};
      default: return spa_pkg::CoefWidth'($urandom);
    endcase
  endfunction

  // one pair of polynomials followed by an add; overfill pushes both stores past full
  task automatic poly_round(input logic overfill);
    int                                   n_first;
    int                                   n_second;
    int                                   fi;
    int                                   si;
    int                                   idx;
    logic                                 narrow;
    logic [spa_pkg::ExpWidth-1:0]         base;
    logic [spa_pkg::ExpWidth-1:0]         e;
    logic signed [spa_pkg::CoefWidth-1:0] c;
    logic [spa_pkg::ExpWidth-1:0]         first_exps[$];
    logic signed [spa_pkg::CoefWidth-1:0] first_coefs[$];
    n_first = overfill ? spa_pkg::MaxTerms + 2 : pick_size();
    n_second = overfill ? spa_pkg::MaxTerms + 1 : pick_size();
    narrow = ($urandom_range(2) != 0);
    base = spa_pkg::ExpWidth'($urandom_range(255 - 7));
    fi = 0;
    si = 0;
    while (fi < n_first || si < n_second) begin
      if ($urandom_range(19) == 0)
        send_word(CmdUnused, spa_pkg::ExpWidth'($urandom), spa_pkg::CoefWidth'($urandom));
      e = narrow ? base + spa_pkg::ExpWidth'($urandom_range(7))
                 : spa_pkg::ExpWidth'($urandom);
      c = pick_coef();
      if (fi < n_first && (si >= n_second || $urandom_range(1) == 1)) begin
        first_exps.push_back(e);
        first_coefs.push_back(c);
        send_word(spa_pkg::CmdLoadFirst, e, c);
        fi++;
      end else begin
        // often mirror a first term so the pair cancels
        if (first_exps.size() != 0 && $urandom_range(2) == 0) begin
          idx = $urandom_range(first_exps.size() - 1);
          e = first_exps[idx];
          c = -first_coefs[idx];
        end
        send_word(spa_pkg::CmdLoadSecond, e, c);
        si++;
      end
    end
    send_word(spa_pkg::CmdAdd, spa_pkg::ExpWidth'($urandom), spa_pkg::CoefWidth'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty sum, ignored command, extremes, cancellation, repeated exponents
    send_word(spa_pkg::CmdAdd, 8'hFF, 16'sh7FFF);
    send_word(CmdUnused, 8'h5A, 16'sh1234);
    send_word(spa_pkg::CmdLoadFirst, 8'd255, 16'sh7FFF);
    send_word(spa_pkg::CmdLoadSecond, 8'd255, 16'sh7FFF);
    send_word(spa_pkg::CmdLoadFirst, 8'd0, 16'sh8000);
    send_word(spa_pkg::CmdLoadSecond, 8'd0, 16'sh8000);
    send_word(spa_pkg::CmdLoadFirst, 8'd10, 16'sd5);
    send_word(spa_pkg::CmdLoadSecond, 8'd10, -16'sd5);
    send_word(spa_pkg::CmdLoadFirst, 8'd7, 16'sd1);
    send_word(spa_pkg::CmdLoadFirst, 8'd7, 16'sd2);
    send_word(spa_pkg::CmdLoadSecond, 8'd7, 16'sd3);
    send_word(spa_pkg::CmdLoadFirst, 8'hAA, 16'sh5555);
    send_word(spa_pkg::CmdLoadSecond, 8'h55, 16'shAAAA);
    send_word(spa_pkg::CmdAdd, 8'h00, 16'sh0000);
    send_word(spa_pkg::CmdLoadFirst, 8'd3, -16'sd7);
    send_word(spa_pkg::CmdLoadSecond, 8'd3, 16'sd7);
    send_word(spa_pkg::CmdAdd, 8'h00, 16'sh0000);
    wait_drained();

    send_idle_pct = 11;
    recv_idle_pct <= 56;
    poly_round(1'b1);
    while (words_sent < 150) poly_round(1'b0);
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct <= 11;
    while (words_sent < 280) poly_round(1'b0);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_go <= ~hold_go;
    poly_round(1'b1);
    while (words_sent < 410) poly_round(1'b0);
    wait_drained();

    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
